### rtl/isrch_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isrch_pkg: shared constants and types for the interpolation search core
// Widths of the table, keys and the divider handshake.
// ----------------------------------------------------------------------------
package isrch_pkg;
	localparam int TableDepth = 1024;
	localparam int AddrW      = 10;
	localparam int CountW     = 11;
	localparam int ValueW     = 32;
	localparam int QuotW      = 10;
	localparam logic OpWrite  = 1'b0;
	localparam logic OpSearch = 1'b1;

	typedef struct packed {
		logic              start;
		logic [ValueW-1:0] d;
		logic [QuotW-1:0]  n;
		logic [ValueW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QuotW-1:0] q;
	} div_rsp_t;
endpackage

### rtl/interpolation_search_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interpolation_search_core: table of sorted keys with interpolation search
// Write items store one entry; search items return found and position.
// ----------------------------------------------------------------------------
//  channel | handshake        | payload
//  in      | in_valid/in_stall| op, entry_index, value
//  out     | out_valid/stall  | found, position
//  cfg     | cfg_valid/ready  | cfg_data (entry_count)
//
// A write is stored in the cycle it is accepted. A search passes S_INIT and S_OUT
// around its probes. A probe reads first, last and mid, each with an address and
// a data phase, adds a check and a compare state and a serial divide, which is
// skipped when both ends are equal; a target out of range ends it at the check.
// The single-port table and the bit-serial divider set the search time.
// One item is worked at a time. Reset clears control and entry_count = 1.
// A held result waits in the output register while out_stall is high.
module interpolation_search_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [9:0]  entry_index,
	input  logic signed [31:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        found,
	output logic [9:0]  position,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [10:0] cfg_data
);
	localparam int W = isrch_pkg::ValueW;
	localparam int A = isrch_pkg::AddrW;

	typedef enum logic [3:0] {
		S_IDLE, S_INIT, S_RDF, S_RDL, S_CHK, S_DIV, S_RDM, S_CMP, S_OUT
	} state_t;

	state_t state_q;
	logic [W-1:0] mem [isrch_pkg::TableDepth];
	logic [W-1:0] rd_q, t_q, af_q, al_q;
	logic [A-1:0] first_q, last_q, mid_q;
	logic [isrch_pkg::CountW-1:0] count_q;
	logic [A-1:0] raddr;
	logic         ph_q;
	logic         found_q;
	logic [A-1:0] pos_q;
	logic         res_found_q;
	logic [A-1:0] res_pos_q;
	isrch_pkg::div_req_t dreq;
	isrch_pkg::div_rsp_t drsp;

	logic acc;
	assign in_stall  = (state_q != S_IDLE);
	assign acc       = in_valid && !in_stall;
	assign cfg_ready = (state_q == S_IDLE);

	always_ff @(posedge clk) begin
		if (acc && op == isrch_pkg::OpWrite)
			mem[entry_index] <= value;
		rd_q <= mem[raddr] ^ {1'b1, {(W-1){1'b0}}};
	end

	always_comb begin
		unique case (state_q)
			S_RDF:   raddr = first_q;
			S_RDL:   raddr = last_q;
			default: raddr = mid_q;
		endcase
	end

	assign dreq.start = (state_q == S_CHK) && !(af_q > t_q || al_q < t_q) && (al_q != af_q);
	assign dreq.d     = t_q - af_q;
	assign dreq.n     = last_q - first_q;
	assign dreq.den   = al_q - af_q;

	isrch_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= 11'd1;
			ph_q         <= 1'b0;
			out_valid    <= 1'b0;
			found_q      <= 1'b0;
			pos_q        <= '0;
			res_found_q  <= 1'b0;
			res_pos_q    <= '0;
			first_q      <= '0;
			last_q       <= '0;
			mid_q        <= '0;
			t_q          <= '0;
			af_q         <= '0;
			al_q         <= '0;
		end else begin
			if (cfg_valid && cfg_ready)
				count_q <= cfg_data;
			unique case (state_q)
				S_IDLE: begin
					if (acc && op == isrch_pkg::OpSearch) begin
						t_q     <= value ^ {1'b1, {(W-1){1'b0}}};
						found_q <= 1'b0;
						pos_q   <= '0;
						state_q <= S_INIT;
					end
				end
				S_INIT: begin
					first_q <= '0;
					if (count_q == '0)
						state_q <= S_OUT;
					else begin
						last_q  <= (count_q > 11'd1024) ? A'(1023) : A'(count_q - 1'b1);
						ph_q    <= 1'b0;
						state_q <= S_RDF;
					end
				end
				// each read: address phase, then the registered data is taken in the data phase
				S_RDF: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						af_q <= rd_q; state_q <= S_RDL; ph_q <= 1'b0;
					end
				end
				S_RDL: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						al_q <= rd_q; state_q <= S_CHK; ph_q <= 1'b0;
					end
				end
				S_CHK: begin
					if (af_q > t_q || al_q < t_q)
						state_q <= S_OUT;
					else if (al_q == af_q) begin
						mid_q <= first_q; state_q <= S_RDM;
					end else
						state_q <= S_DIV;
				end
				S_DIV: begin
					if (drsp.done) begin
						mid_q <= first_q + drsp.q; state_q <= S_RDM;
					end
				end
				S_RDM: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						ph_q <= 1'b0; state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (rd_q == t_q) begin
						found_q <= 1'b1; pos_q <= mid_q; state_q <= S_OUT;
					end else if (t_q < rd_q) begin
						if (mid_q == '0 || mid_q - 1'b1 < first_q)
							state_q <= S_OUT;
						else begin
							last_q <= mid_q - 1'b1; state_q <= S_RDF;
						end
					end else begin
						if (mid_q == last_q)
							state_q <= S_OUT;
						else begin
							first_q <= mid_q + 1'b1; state_q <= S_RDF;
						end
					end
				end
				// the output register holds its own copy, so a stalled result
				// survives the next search
				S_OUT: begin
					if (!out_valid || !out_stall) begin
						out_valid   <= 1'b1;
						res_found_q <= found_q;
						res_pos_q   <= pos_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (out_valid && !out_stall && state_q != S_OUT)
				out_valid <= 1'b0;
		end
	end

	assign found    = res_found_q;
	assign position = res_pos_q;
endmodule

### rtl/isrch_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isrch_div: bit-serial scaled quotient
// floor(d * n / den) for d <= den, one bit of n per cycle, remainder kept
// below den so that the result stays within n.
// ----------------------------------------------------------------------------
module isrch_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  isrch_pkg::div_req_t  req,
	output isrch_pkg::div_rsp_t  rsp
);
	localparam int W = isrch_pkg::ValueW;
	localparam int N = isrch_pkg::QuotW;

	logic [W-1:0] r_q, d_q, den_q;
	logic [N-1:0] n_q, q_q;
	logic [$clog2(N+1)-1:0] cnt_q;
	logic busy_q, done_q;

	logic [W:0]   dbl, r1, add1;
	logic [W-1:0] r_a;
	logic         b_a, b_b;
	logic [W-1:0] r_b;

	always_comb begin
		dbl = {r_q, 1'b0};
		b_a = dbl >= {1'b0, den_q};
		r1  = b_a ? dbl - {1'b0, den_q} : dbl;
		r_a = r1[W-1:0];
		add1 = {1'b0, r_a} + {1'b0, d_q};
		b_b = n_q[N-1] && (add1 >= {1'b0, den_q});
		if (!n_q[N-1])
			r_b = r_a;
		else if (b_b)
			r_b = W'(add1 - {1'b0, den_q});
		else
			r_b = add1[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ($clog2(N+1))'(N - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// the quotient never exceeds n, so N bits hold all of it
	always_ff @(posedge clk) begin
		if (req.start) begin
			r_q   <= '0;
			q_q   <= '0;
			d_q   <= req.d;
			n_q   <= req.n;
			den_q <= req.den;
		end else if (busy_q) begin
			r_q <= r_b;
			n_q <= {n_q[N-2:0], 1'b0};
			q_q <= {q_q[N-2:0], 1'b0} + N'(b_a) + N'(b_b);
		end
	end

	assign rsp.done = done_q;
	assign rsp.q    = q_q;
endmodule

### rtl/isrch_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isrch_checker: port-level checks for the interpolation search core
// Handshake and result-shape properties seen at the top level.
// ----------------------------------------------------------------------------
module isrch_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic       found,
	input logic [9:0] position,
	input logic       cfg_ready
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(position) && $stable(found))
		else $error("stalled result changed");
	a_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> position == 10'd0)
		else $error("miss with nonzero position");
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready == !in_stall)
		else $error("cfg ready while busy");
endmodule

bind interpolation_search_core isrch_checker u_chk (.*);

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for interpolation_search_core
// Loads sorted and unsorted tables, runs directed and random searches with random
// idling on both channels, and checks every result against a local model.
// ----------------------------------------------------------------------------
module tb_top;
	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              op = isrch_pkg::OpWrite;
	logic [9:0]        entry_index = '0;
	logic signed [31:0] value = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              found;
	logic [9:0]        position;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [10:0]       cfg_data = '0;

	typedef struct {
		logic       hit;
		logic [9:0] pos;
	} search_res_t;

	typedef struct {
		logic              op;
		logic [9:0]        idx;
		logic signed [31:0] val;
		logic              chk;
		logic              hit;
		logic [9:0]        pos;
	} vec_t;

	logic signed [31:0] model_table [isrch_pkg::TableDepth];
	logic [10:0]        model_count = 11'd1;
	search_res_t        expected_q [$];
	int                 errors = 0;
	int                 send_idle = 0;
	int                 recv_stall = 0;
	longint             cycles = 0;

	always #4 clk = ~clk;

	interpolation_search_core u_top (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 64'd3000000) begin
			$display("FAIL");
			$finish;
		end
	end

	// floor(d*n/den) exactly, on wide integers
	function automatic search_res_t search_table(logic signed [31:0] tgt);
		longint cnt, first, last, mid, af, al, am, t;
		search_res_t r;
		r.hit = 1'b0;
		r.pos = '0;
		cnt = (model_count > isrch_pkg::TableDepth) ? isrch_pkg::TableDepth : model_count;
		t = tgt;
		if (cnt == 0)
			return r;
		first = 0;
		last = cnt - 1;
		while (first <= last) begin
			af = model_table[first];
			al = model_table[last];
			if (af > t || al < t)
				break;
			if (al == af)
				mid = first;
			else
				mid = first + ((t - af) * (last - first)) / (al - af);
			am = model_table[mid];
			if (am == t) begin
				r.hit = 1'b1;
				r.pos = mid[9:0];
				break;
			end
			if (t < am) begin
				if (mid == 0)
					break;
				last = mid - 1;
			end else begin
				first = mid + 1;
			end
		end
		return r;
	endfunction

	// result side: random stall, compare on transfer
	always @(posedge clk) begin
		search_res_t e;
		if (out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$error("unexpected result found=%0d position=%0d", found, position);
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (found !== e.hit) begin
					$error("found: expected %0d actual %0d", e.hit, found);
					errors++;
				end
				if (position !== e.pos) begin
					$error("position: expected %0d actual %0d", e.pos, position);
					errors++;
				end
			end
		end
		out_stall <= ($urandom_range(99) < recv_stall);
	end

	// valid stays up after the transfer until the next item or a wait
	task automatic send_item(logic o, logic [9:0] idx, logic signed [31:0] v);
		search_res_t r;
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		entry_index <= idx;
		value <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (o == isrch_pkg::OpWrite) begin
			model_table[idx] = v;
		end else begin
			r = search_table(v);
			expected_q.push_back(r);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_count(logic [10:0] c);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= c;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		model_count = c;
	endtask

	// ascending table of n entries; wide spread when sp is large
	task automatic load_sorted(int n, int sp, logic signed [31:0] base);
		longint v;
		v = base;
		for (int i = 0; i < n; i++) begin
			send_item(isrch_pkg::OpWrite, i[9:0], v[31:0]);
			v = v + $urandom_range(sp);
			if (v > 64'sd2147483647)
				v = 64'sd2147483647;
		end
	endtask

	function automatic logic signed [31:0] pick_target(int n);
		int k;
		k = $urandom_range(n - 1);
		case ($urandom_range(3))
			0: return $urandom;
			1: return model_table[k] + 1;
			default: return model_table[k];
		endcase
	endfunction

	vec_t dir [] = '{
		'{isrch_pkg::OpWrite, 10'd0, 32'sh80000000, 1'b0, 1'b0, 10'd0},
		'{isrch_pkg::OpSearch, 10'd0, 32'sh80000000, 1'b1, 1'b1, 10'd0},
		'{isrch_pkg::OpSearch, 10'd0, 32'sh7fffffff, 1'b1, 1'b0, 10'd0},
		'{isrch_pkg::OpWrite, 10'd1, 32'sh80000000, 1'b0, 1'b0, 10'd0},
		'{isrch_pkg::OpWrite, 10'd2, -32'sd1, 1'b0, 1'b0, 10'd0},
		'{isrch_pkg::OpWrite, 10'd3, 32'sd0, 1'b0, 1'b0, 10'd0},
		'{isrch_pkg::OpWrite, 10'd4, 32'sd5, 1'b0, 1'b0, 10'd0},
		'{isrch_pkg::OpWrite, 10'd1023, 32'sh7fffffff, 1'b0, 1'b0, 10'd0}
	};

	int phase_idle [4] = '{0, 65, 0, 22};
	int phase_stall [4] = '{0, 0, 65, 22};

	initial begin
		int n;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// count of one, then a short table
		foreach (dir[i]) begin
			send_item(dir[i].op, dir[i].idx, dir[i].val);
			if (dir[i].chk) begin
				void'(expected_q.pop_back());
				expected_q.push_back('{dir[i].hit, dir[i].pos});
			end
		end
		write_count(11'd5);
		for (int i = -2; i < 7; i++)
			send_item(isrch_pkg::OpSearch, 10'd0, i);
		send_item(isrch_pkg::OpSearch, 10'd0, 32'sh7fffffff);
		write_count(11'd0);
		send_item(isrch_pkg::OpSearch, 10'd0, 32'sd0);
		// full table with extremes at both ends
		load_sorted(1024, 8000000, 32'sh80000000);
		send_item(isrch_pkg::OpWrite, 10'd1023, 32'sh7fffffff);
		write_count(11'd2047);
		send_item(isrch_pkg::OpSearch, 10'd0, 32'sh7fffffff);
		send_item(isrch_pkg::OpSearch, 10'd0, 32'sh80000000);
		write_count(11'd1024);
		for (int i = 0; i < 10; i++)
			send_item(isrch_pkg::OpSearch, 10'd0, pick_target(1024));
		// unsorted content, every entry written
		write_count(11'd16);
		for (int i = 0; i < 16; i++)
			send_item(isrch_pkg::OpWrite, i[9:0], $urandom);
		for (int i = 0; i < 20; i++)
			send_item(isrch_pkg::OpSearch, 10'd0, pick_target(16));
		for (int ph = 0; ph < 4; ph++) begin
			send_idle = phase_idle[ph];
			recv_stall = phase_stall[ph];
			for (int set = 0; set < 3; set++) begin
				n = $urandom_range(24, 1);
				write_count(n[10:0]);
				load_sorted(n, ($urandom_range(1)) ? 3 : 20000000,
					$urandom_range(1) ? 32'sh80000000 + $urandom_range(1000)
					: -$signed($urandom_range(100000)));
				for (int k = 0; k < 16; k++)
					send_item(isrch_pkg::OpSearch, 10'($urandom), pick_target(n));
			end
		end
		// sender waits for everything before continuing
		send_idle = 22;
		recv_stall = 22;
		drain();
		for (int k = 0; k < 40; k++)
			send_item(isrch_pkg::OpSearch, 10'($urandom), pick_target(n));
		drain();
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

### sim.f
rtl/isrch_pkg.sv
rtl/isrch_div.sv
rtl/interpolation_search_core.sv
rtl/isrch_checker.sv
test/tb_top.sv
